### design/bfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types, codes and defaults for the shortest path core.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  // node fields are fixed at six bits, node counts at seven
  localparam int NODE_BITS = 6;
  localparam int NCNT_BITS = 7;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_MAX_EDGES   = 256;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_DIST_BITS   = 32;

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  localparam logic [NCNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PIN,
    ST_RELAX,
    ST_DRAIN,
    ST_COPY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 init_we;
    logic                 pin_we;
    logic                 relax_issue;
    logic                 copy_rd;
    logic                 emit_rd;
    logic [NCNT_BITS-1:0] idx;
  } ctl_t;

endpackage

### design/bfsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module bfsp_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bfsp_edge_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_edge_store
// Edge list memory with fill count; appends edges, clears by resetting count.
// ----------------------------------------------------------------------------
module bfsp_edge_store #(
  parameter int MAX_EDGES   = bfsp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = bfsp_pkg::DEF_WEIGHT_BITS,
  parameter int EA          = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ET          = $clog2(MAX_EDGES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          add,
  input  logic                          clear,
  input  logic [bfsp_pkg::NODE_BITS-1:0] tail,
  input  logic [bfsp_pkg::NODE_BITS-1:0] head,
  input  logic [WEIGHT_BITS-1:0]        weight,
  input  logic [EA-1:0]                 raddr,
  output logic [bfsp_pkg::NODE_BITS-1:0] rd_tail,
  output logic [bfsp_pkg::NODE_BITS-1:0] rd_head,
  output logic [WEIGHT_BITS-1:0]        rd_weight,
  output logic [ET-1:0]                 total
);

  localparam int NB = bfsp_pkg::NODE_BITS;
  localparam int EW = 2 * NB + WEIGHT_BITS;
  localparam logic [ET-1:0] FULL = ET'(MAX_EDGES);

  logic [EW-1:0] mem [MAX_EDGES];
  logic [EW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (add && total != FULL) begin
      mem[total[EA-1:0]] <= {tail, head, weight};
    end
    rd_word <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (clear) begin
      total <= '0;
    end else if (add && total != FULL) begin
      total <= total + ET'(1);
    end
  end

  assign rd_tail   = rd_word[EW-1 -: NB];
  assign rd_head   = rd_word[WEIGHT_BITS +: NB];
  assign rd_weight = rd_word[WEIGHT_BITS-1:0];

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= FULL)
    else $error("edge count past capacity");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (total == FULL && !clear) |=> total == FULL)
    else $error("full edge store changed count without clear");

endmodule

### design/bfsp_relax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_relax
// Edge relaxation pipeline: distance lookup, saturating sum, compare, update.
// ----------------------------------------------------------------------------
module bfsp_relax #(
  parameter int MAX_NODES   = bfsp_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = bfsp_pkg::DEF_WEIGHT_BITS,
  parameter int DIST_BITS   = bfsp_pkg::DEF_DIST_BITS,
  parameter int NA          = $clog2(MAX_NODES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           issue,
  input  logic [bfsp_pkg::NCNT_BITS-1:0] n,
  input  logic [bfsp_pkg::NODE_BITS-1:0] edge_tail,
  input  logic [bfsp_pkg::NODE_BITS-1:0] edge_head,
  input  logic [WEIGHT_BITS-1:0]         edge_w,
  input  logic [DIST_BITS:0]             prev_q,
  input  logic [DIST_BITS:0]             curr_q,
  output logic [NA-1:0]                  prev_raddr,
  output logic [NA-1:0]                  curr_raddr,
  output logic                           wr_en,
  output logic [NA-1:0]                  wr_addr,
  output logic [DIST_BITS:0]             wr_data,
  output logic                           busy
);

  localparam int D  = DIST_BITS;
  localparam int W  = WEIGHT_BITS;
  localparam int SW = ((D > W) ? D : W) + 1;
  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-D+1){1'b0}}, {(D-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-D+1){1'b1}}, {(D-1){1'b0}}};

  logic             b_valid;
  logic             in_range;
  logic             c_valid;
  logic [NA-1:0]    c_addr;
  logic [W-1:0]     c_w;
  logic             c_fwd;
  logic [D:0]       c_fwd_data;

  logic [D:0]       cur_word;
  logic signed [SW-1:0] sum;
  logic [D-1:0]     cand;

  // stage b: edge word is out of the store, look up both endpoints
  assign in_range   = ({1'b0, edge_tail} < n) && ({1'b0, edge_head} < n);
  assign prev_raddr = edge_tail[NA-1:0];
  assign curr_raddr = edge_head[NA-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      c_fwd   <= 1'b0;
    end else begin
      b_valid <= issue;
      c_valid <= b_valid && in_range;
      // the read in stage b misses a write landing on the same node now
      c_fwd   <= wr_en && (wr_addr == edge_head[NA-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    c_addr     <= edge_head[NA-1:0];
    c_w        <= edge_w;
    c_fwd_data <= wr_data;
  end

  // stage c: saturating candidate against the current head distance
  always_comb begin
    cur_word = c_fwd ? c_fwd_data : curr_q;
    sum = $signed({{(SW-D){prev_q[D-1]}}, prev_q[D-1:0]})
        + $signed({{(SW-W){c_w[W-1]}}, c_w});
    if (sum > SUM_MAX) begin
      cand = SUM_MAX[D-1:0];
    end else if (sum < SUM_MIN) begin
      cand = SUM_MIN[D-1:0];
    end else begin
      cand = sum[D-1:0];
    end
  end

  assign wr_en   = c_valid && prev_q[D]
                 && (!cur_word[D] || ($signed(cand) < $signed(cur_word[D-1:0])));
  assign wr_addr = c_addr;
  assign wr_data = {1'b1, cand};
  assign busy    = b_valid || c_valid;

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({{(bfsp_pkg::NCNT_BITS-NA){1'b0}}, wr_addr} < n))
    else $error("relaxation wrote a node outside node count");

  a_wr_from_pipe: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(b_valid))
    else $error("update without an edge in flight");

endmodule

### design/bfsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Run sequencer: init sweep, per-pass pin/relax/copy, final emit sweep.
// ----------------------------------------------------------------------------
module bfsp_ctrl #(
  parameter int MAX_EDGES = bfsp_pkg::DEF_MAX_EDGES,
  parameter int EA        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ET        = $clog2(MAX_EDGES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           run,
  input  logic [bfsp_pkg::NCNT_BITS-1:0] n,
  input  logic                           src_ok,
  input  logic [ET-1:0]                  edge_total,
  input  logic                           pipe_busy,
  output logic                           busy,
  output logic [EA-1:0]                  edge_addr,
  output bfsp_pkg::ctl_t                 ctl
);

  localparam int NC = bfsp_pkg::NCNT_BITS;

  bfsp_pkg::state_t state, state_next;
  logic [NC-1:0] idx;
  logic [NC-1:0] pass_left;
  logic [ET-1:0] eaddr;
  logic          idx_end;
  logic          edge_end;

  assign idx_end  = (idx == n - NC'(1));
  assign edge_end = ((eaddr + ET'(1)) == edge_total);

  always_comb begin
    state_next = state;
    unique case (state)
      bfsp_pkg::ST_IDLE: begin
        if (run) state_next = bfsp_pkg::ST_INIT;
      end
      bfsp_pkg::ST_INIT: begin
        if (idx_end) begin
          state_next = (n == NC'(1)) ? bfsp_pkg::ST_EMIT : bfsp_pkg::ST_PIN;
        end
      end
      bfsp_pkg::ST_PIN: begin
        state_next = (edge_total == '0) ? bfsp_pkg::ST_DRAIN : bfsp_pkg::ST_RELAX;
      end
      bfsp_pkg::ST_RELAX: begin
        if (edge_end) state_next = bfsp_pkg::ST_DRAIN;
      end
      bfsp_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          // the copy after the final pass is never read
          state_next = (pass_left == NC'(1)) ? bfsp_pkg::ST_EMIT : bfsp_pkg::ST_COPY;
        end
      end
      bfsp_pkg::ST_COPY: begin
        if (idx_end) state_next = bfsp_pkg::ST_PIN;
      end
      bfsp_pkg::ST_EMIT: begin
        if (idx_end) state_next = bfsp_pkg::ST_IDLE;
      end
      default: state_next = bfsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.idx         = idx;
    busy            = 1'b1;
    unique case (state)
      bfsp_pkg::ST_IDLE:  busy            = 1'b0;
      bfsp_pkg::ST_INIT:  ctl.init_we     = 1'b1;
      bfsp_pkg::ST_PIN:   ctl.pin_we      = src_ok;
      bfsp_pkg::ST_RELAX: ctl.relax_issue = 1'b1;
      bfsp_pkg::ST_DRAIN: ;
      bfsp_pkg::ST_COPY:  ctl.copy_rd     = 1'b1;
      bfsp_pkg::ST_EMIT:  ctl.emit_rd     = 1'b1;
      default:            busy            = 1'b1;
    endcase
  end

  assign edge_addr = eaddr[EA-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfsp_pkg::ST_IDLE;
      idx       <= '0;
      pass_left <= '0;
      eaddr     <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        idx <= '0;
      end else begin
        idx <= idx + NC'(1);
      end
      if (state == bfsp_pkg::ST_IDLE) begin
        pass_left <= n - NC'(1);
      end else if (state == bfsp_pkg::ST_DRAIN && !pipe_busy) begin
        pass_left <= pass_left - NC'(1);
      end
      if (state == bfsp_pkg::ST_RELAX) begin
        eaddr <= eaddr + ET'(1);
      end else begin
        eaddr <= '0;
      end
    end
  end

endmodule

### design/bellman_ford_shortest_path_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core
// Single-source shortest paths over a stored directed edge list.
// ----------------------------------------------------------------------------
// add-edge and clear requests leave busy low
// a run makes n-1 relaxation passes over the E stored edges for n >= 2 nodes
// and none for one node; each pass feeds one edge per cycle through the distance memories
// results come one per cycle on result_valid at the end of a run; the receiver cannot stall
// reset clears control state and the edge count; memories are not swept
module bellman_ford_shortest_path_core #(
  parameter int MAX_NODES   = bfsp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = bfsp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = bfsp_pkg::DEF_WEIGHT_BITS,
  parameter int DIST_BITS   = bfsp_pkg::DEF_DIST_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [bfsp_pkg::NODE_BITS-1:0]  edge_from,
  input  logic [bfsp_pkg::NODE_BITS-1:0]  edge_to,
  input  logic signed [WEIGHT_BITS-1:0]   edge_weight,
  output logic                            result_valid,
  output logic [bfsp_pkg::NODE_BITS-1:0]  node_index,
  output logic signed [DIST_BITS-1:0]     distance,
  output logic                            reachable,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfsp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bfsp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bfsp_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  localparam int NC = bfsp_pkg::NCNT_BITS;
  localparam int NB = bfsp_pkg::NODE_BITS;
  localparam int NA = $clog2(MAX_NODES);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET = $clog2(MAX_EDGES + 1);
  localparam int D  = DIST_BITS;
  localparam logic [NC-1:0] NMAX     = NC'(MAX_NODES);
  localparam logic [D-1:0]  INT_MAX  = {1'b0, {(D-1){1'b1}}};

  logic [NC-1:0] node_count;
  logic [NB-1:0] source_node;
  logic [NC-1:0] n_eff;
  logic          src_ok;
  logic          accept;
  logic          run;

  bfsp_pkg::ctl_t ctl;
  logic [EA-1:0]  edge_addr;
  logic [ET-1:0]  edge_total;
  logic [NB-1:0]  rd_tail;
  logic [NB-1:0]  rd_head;
  logic [WEIGHT_BITS-1:0] rd_weight;

  logic [NA-1:0]  prev_raddr;
  logic [NA-1:0]  relax_curr_raddr;
  logic           relax_we;
  logic [NA-1:0]  relax_waddr;
  logic [D:0]     relax_wdata;
  logic           pipe_busy;

  logic           curr_we;
  logic [NA-1:0]  curr_waddr;
  logic [D:0]     curr_wdata;
  logic [NA-1:0]  curr_raddr;
  logic [D:0]     curr_q;
  logic           prev_we;
  logic [NA-1:0]  prev_waddr;
  logic [D:0]     prev_wdata;
  logic [D:0]     prev_q;
  logic [D:0]     init_word;

  logic           copy_v;
  logic [NA-1:0]  copy_addr;
  logic [NC-1:0]  emit_idx;

  // ---- configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= bfsp_pkg::NODE_COUNT_RESET;
      source_node <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        bfsp_pkg::REG_NODE_COUNT:  node_count  <= pwdata[NC-1:0];
        bfsp_pkg::REG_SOURCE_NODE: source_node <= pwdata[NB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bfsp_pkg::REG_NODE_COUNT:  prdata = bfsp_pkg::DATA_BITS'(node_count);
      bfsp_pkg::REG_SOURCE_NODE: prdata = bfsp_pkg::DATA_BITS'(source_node);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    priority if (node_count == '0) begin
      n_eff = NC'(1);
    end else if (node_count > NMAX) begin
      n_eff = NMAX;
    end else begin
      n_eff = node_count;
    end
  end

  assign src_ok = ({1'b0, source_node} < n_eff);
  assign accept = start && !busy;
  assign run    = accept && (req_type == bfsp_pkg::REQ_RUN);

  // ---- edge list
  bfsp_edge_store #(
    .MAX_EDGES  (MAX_EDGES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .EA         (EA),
    .ET         (ET)
  ) u_edges (
    .clk      (clk),
    .rst      (rst),
    .add      (accept && (req_type == bfsp_pkg::REQ_ADD)),
    .clear    (accept && (req_type == bfsp_pkg::REQ_CLEAR)),
    .tail     (edge_from),
    .head     (edge_to),
    .weight   (edge_weight),
    .raddr    (edge_addr),
    .rd_tail  (rd_tail),
    .rd_head  (rd_head),
    .rd_weight(rd_weight),
    .total    (edge_total)
  );

  // ---- sequencer
  bfsp_ctrl #(
    .MAX_EDGES(MAX_EDGES),
    .EA       (EA),
    .ET       (ET)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .n         (n_eff),
    .src_ok    (src_ok),
    .edge_total(edge_total),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .edge_addr (edge_addr),
    .ctl       (ctl)
  );

  // ---- relaxation
  bfsp_relax #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .DIST_BITS  (DIST_BITS),
    .NA         (NA)
  ) u_relax (
    .clk       (clk),
    .rst       (rst),
    .issue     (ctl.relax_issue),
    .n         (n_eff),
    .edge_tail (rd_tail),
    .edge_head (rd_head),
    .edge_w    (rd_weight),
    .prev_q    (prev_q),
    .curr_q    (curr_q),
    .prev_raddr(prev_raddr),
    .curr_raddr(relax_curr_raddr),
    .wr_en     (relax_we),
    .wr_addr   (relax_waddr),
    .wr_data   (relax_wdata),
    .busy      (pipe_busy)
  );

  // ---- distance memories, word is {reached, distance}
  assign init_word = {(ctl.idx == {1'b0, source_node}), {D{1'b0}}};

  always_comb begin
    curr_we    = ctl.init_we || ctl.pin_we || relax_we;
    curr_waddr = relax_waddr;
    curr_wdata = relax_wdata;
    priority if (ctl.init_we) begin
      curr_waddr = ctl.idx[NA-1:0];
      curr_wdata = init_word;
    end else if (ctl.pin_we) begin
      curr_waddr = source_node[NA-1:0];
      curr_wdata = {1'b1, {D{1'b0}}};
    end else begin
      curr_waddr = relax_waddr;
      curr_wdata = relax_wdata;
    end
  end

  assign curr_raddr = (ctl.copy_rd || ctl.emit_rd) ? ctl.idx[NA-1:0] : relax_curr_raddr;

  bfsp_ram #(
    .WIDTH(D + 1),
    .DEPTH(MAX_NODES),
    .AW   (NA)
  ) u_curr (
    .clk  (clk),
    .we   (curr_we),
    .waddr(curr_waddr),
    .wdata(curr_wdata),
    .raddr(curr_raddr),
    .rdata(curr_q)
  );

  // copy sweep writes prev in the cycle after its read of the current distances
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      copy_v       <= ctl.copy_rd;
      result_valid <= ctl.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= ctl.idx[NA-1:0];
    emit_idx  <= ctl.idx;
  end

  assign prev_we    = ctl.init_we || copy_v;
  assign prev_waddr = ctl.init_we ? ctl.idx[NA-1:0] : copy_addr;
  assign prev_wdata = ctl.init_we ? init_word : curr_q;

  bfsp_ram #(
    .WIDTH(D + 1),
    .DEPTH(MAX_NODES),
    .AW   (NA)
  ) u_prev (
    .clk  (clk),
    .we   (prev_we),
    .waddr(prev_waddr),
    .wdata(prev_wdata),
    .raddr(prev_raddr),
    .rdata(prev_q)
  );

  // ---- results
  assign node_index = emit_idx[NB-1:0];
  assign reachable  = curr_q[D];
  assign distance   = curr_q[D] ? curr_q[D-1:0] : INT_MAX;
  assign last       = (emit_idx == n_eff - NC'(1));

  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    run |=> busy)
    else $error("run request did not start a run");

  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result outside a run");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result after the final node");

endmodule

### tb/bellman_ford_shortest_path_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core_tb
// Loads directed edge lists and runs the shortest path core under many node
// counts and sources. A behavioral solver in the bench works out every node
// distance, and a monitor compares each emitted result against it in order.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_core_tb;

  localparam int MAXN = bfsp_pkg::DEF_MAX_NODES;
  localparam int MAXE = bfsp_pkg::DEF_MAX_EDGES;
  localparam int WB   = bfsp_pkg::DEF_WEIGHT_BITS;
  localparam int DB   = bfsp_pkg::DEF_DIST_BITS;
  localparam int NB   = bfsp_pkg::NODE_BITS;
  localparam int NC   = bfsp_pkg::NCNT_BITS;
  localparam int AB   = bfsp_pkg::ADDR_BITS;
  localparam int DW   = bfsp_pkg::DATA_BITS;
  localparam longint DIST_TOP    = (64'sd1 <<< (DB - 1)) - 1;
  localparam longint DIST_BOTTOM = -DIST_TOP - 1;
  localparam int STALL_LIMIT = 100000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [NB-1:0]        node;
    logic signed [DB-1:0] dist_val;
    logic                 reach;
    logic                 is_last;
  } node_distance_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            req_type = bfsp_pkg::REQ_ADD;
  logic [NB-1:0]         edge_from = '0;
  logic [NB-1:0]         edge_to = '0;
  logic signed [WB-1:0]  edge_weight = '0;
  logic                  result_valid;
  logic [NB-1:0]         node_index;
  logic signed [DB-1:0]  distance;
  logic                  reachable;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AB-1:0]         paddr = '0;
  logic [DW-1:0]         pwdata = '0;
  logic [DW-1:0]         prdata;
  logic                  pready;

  // solver state: configuration and edge store as the core should hold them
  logic [NC-1:0]         cfg_nodes = bfsp_pkg::NODE_COUNT_RESET;
  logic [NB-1:0]         cfg_source = '0;
  logic [NB-1:0]         edge_tails [MAXE];
  logic [NB-1:0]         edge_heads [MAXE];
  longint                edge_weights [MAXE];
  int                    edge_count = 0;
  node_distance_t        pending_distances [$];

  int error_count = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int results_seen = 0;
  int idle_pct = 0;

  bellman_ford_shortest_path_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int effective_nodes();
    int n;
    n = int'(cfg_nodes);
    if (n == 0) n = 1;
    if (n > MAXN) n = MAXN;
    return n;
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > DIST_TOP) return DIST_TOP;
    if (s < DIST_BOTTOM) return DIST_BOTTOM;
    return s;
  endfunction

  // jacobi relaxation: every pass reads only the previous pass's distances
  function automatic void solve_paths();
    int n, src, u, v;
    longint prv [MAXN];
    longint cur [MAXN];
    longint cand;
    bit prv_r [MAXN];
    bit cur_r [MAXN];
    node_distance_t r;
    n = effective_nodes();
    src = int'(cfg_source);
    for (int i = 0; i < n; i++) begin
      prv[i] = 0; cur[i] = 0; prv_r[i] = 1'b0; cur_r[i] = 1'b0;
    end
    if (src < n) begin
      prv_r[src] = 1'b1;
      cur_r[src] = 1'b1;
    end
    for (int p = 0; p + 1 < n; p++) begin
      if (src < n) begin
        cur[src] = 0;
        cur_r[src] = 1'b1;
      end
      for (int e = 0; e < edge_count; e++) begin
        u = int'(edge_tails[e]);
        v = int'(edge_heads[e]);
        if (u < n && v < n && prv_r[u]) begin
          cand = clamp_sum(prv[u], edge_weights[e]);
          if (!cur_r[v] || cand < cur[v]) begin
            cur[v] = cand;
            cur_r[v] = 1'b1;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        prv[i] = cur[i];
        prv_r[i] = cur_r[i];
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node = NB'(i);
      r.dist_val = DB'(cur_r[i] ? cur[i] : DIST_TOP);
      r.reach = cur_r[i];
      r.is_last = (i + 1 == n);
      pending_distances.push_back(r);
    end
  endfunction

  function automatic void predict_request(logic [1:0] req, logic [NB-1:0] tail_node,
                                          logic [NB-1:0] head_node,
                                          logic signed [WB-1:0] wt);
    case (req)
      bfsp_pkg::REQ_ADD: begin
        if (edge_count < MAXE) begin
          edge_tails[edge_count] = tail_node;
          edge_heads[edge_count] = head_node;
          edge_weights[edge_count] = longint'(wt);
          edge_count++;
        end
      end
      bfsp_pkg::REQ_CLEAR: edge_count = 0;
      bfsp_pkg::REQ_RUN:   solve_paths();
      default:   ;
    endcase
  endfunction

  function automatic logic [NB-1:0] pick_node(int eff);
    if ($urandom_range(9) == 0) return NB'($urandom);
    return NB'($urandom_range(eff - 1));
  endfunction

  function automatic logic signed [WB-1:0] pick_weight();
    if ($urandom_range(1)) return WB'($urandom);
    return WB'(int'($urandom_range(60)) - 20);
  endfunction

  // one request: hold start until the core takes it, then maybe go quiet
  task automatic send_request(logic [1:0] req, logic [NB-1:0] tail_node,
                              logic [NB-1:0] head_node, logic signed [WB-1:0] wt);
    start <= 1'b1;
    req_type <= req;
    edge_from <= tail_node;
    edge_to <= head_node;
    edge_weight <= wt;
    do @(negedge clk); while (busy);
    predict_request(req, tail_node, head_node, wt);
    items_sent++;
    if (req == bfsp_pkg::REQ_RUN) runs_sent++;
    @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_type <= 2'($urandom);
      edge_from <= NB'($urandom);
      edge_to <= NB'($urandom);
      edge_weight <= WB'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_distances.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(logic reg_idx, logic [DW-1:0] value);
    logic [DW-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register written at this edge; turn straight into a read-back
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == bfsp_pkg::REG_NODE_COUNT) begin
      cfg_nodes = value[NC-1:0];
      readback = DW'(cfg_nodes);
    end else begin
      cfg_source = value[NB-1:0];
      readback = DW'(cfg_source);
    end
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== readback)
      flag_error($sformatf("register %0d reads %0h, wrote %0h", reg_idx, prdata, readback));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int nodes, int src);
    logic [DW-1:0] junk;
    drain_results();
    // unused upper data bits get noise half the time
    junk = $urandom_range(1) ? DW'($urandom) : '0;
    set_register(bfsp_pkg::REG_NODE_COUNT, (junk << NC) | DW'(nodes));
    set_register(bfsp_pkg::REG_SOURCE_NODE, (junk << NB) | DW'(src));
  endtask

  task automatic test_reset_defaults();
    // 64 nodes, source 0, nothing stored
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
  endtask

  task automatic test_small_graph();
    configure(5, 0);
    send_request(bfsp_pkg::REQ_CLEAR, 6'd63, 6'd63, -16'sd1);
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd1, 16'sd32767);
    send_request(bfsp_pkg::REQ_ADD, 6'd1, 6'd2, -16'sd32768);
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd2, 16'sd5);
    send_request(bfsp_pkg::REQ_ADD, 6'd2, 6'd3, -16'sd1);
    send_request(bfsp_pkg::REQ_ADD, 6'd3, 6'd4, 16'sd0);
    // endpoints beyond the node count are skipped
    send_request(bfsp_pkg::REQ_ADD, 6'd4, 6'd63, 16'sd1);
    send_request(bfsp_pkg::REQ_ADD, 6'd63, 6'd0, -16'sd7);
    // negative cycle back through the pinned source
    send_request(bfsp_pkg::REQ_ADD, 6'd3, 6'd0, -16'sd32768);
    send_request(REQ_UNUSED, 6'd63, 6'd63, -16'sd1);
    send_request(bfsp_pkg::REQ_RUN, 6'd0, 6'd0, 16'sd0);
    send_request(bfsp_pkg::REQ_CLEAR, 6'd0, 6'd0, 16'sd0);
    send_request(bfsp_pkg::REQ_RUN, 6'd63, 6'd63, 16'sd0);
  endtask

  task automatic test_node_count_limits();
    configure(1, 0);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    configure(0, 0);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    // source outside the node count: nothing reachable
    configure(3, 63);
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd1, 16'sd4);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    configure(127, 63);
    send_request(bfsp_pkg::REQ_ADD, 6'd63, 6'd62, -16'sd32768);
    send_request(bfsp_pkg::REQ_ADD, 6'd62, 6'd0, 16'sd2);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    configure(64, 63);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    send_request(bfsp_pkg::REQ_CLEAR, '0, '0, '0);
  endtask

  task automatic test_edge_store_full();
    configure(4, 0);
    send_request(bfsp_pkg::REQ_CLEAR, '0, '0, '0);
    for (int i = 0; i < MAXE; i++)
      send_request(bfsp_pkg::REQ_ADD, pick_node(4), pick_node(4), WB'($urandom));
    // these would shorten every path if the store took them
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd1, -16'sd32768);
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd2, -16'sd32768);
    send_request(bfsp_pkg::REQ_ADD, 6'd0, 6'd3, -16'sd32768);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    configure(64, $urandom_range(63));
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
    configure(2, 1);
    send_request(bfsp_pkg::REQ_CLEAR, '0, '0, '0);
    send_request(bfsp_pkg::REQ_RUN, '0, '0, '0);
  endtask

  task automatic random_graph();
    int pick, nodes, eff;
    if ($urandom_range(1)) begin
      pick = $urandom_range(99);
      if (pick < 75) nodes = $urandom_range(10, 2);
      else if (pick < 88) nodes = $urandom_range(64, 11);
      else if (pick < 94) nodes = $urandom_range(127, 65);
      else nodes = $urandom_range(1);
      eff = (nodes == 0) ? 1 : (nodes > MAXN ? MAXN : nodes);
      configure(nodes, ($urandom_range(99) < 85) ? $urandom_range(eff - 1) : $urandom_range(63));
    end
    eff = effective_nodes();
    if ($urandom_range(99) < 80) begin
      send_request(bfsp_pkg::REQ_CLEAR, NB'($urandom), NB'($urandom), WB'($urandom));
      repeat ($urandom_range(14, 1))
        send_request(bfsp_pkg::REQ_ADD, pick_node(eff), pick_node(eff), pick_weight());
      send_request(bfsp_pkg::REQ_RUN, NB'($urandom), NB'($urandom), WB'($urandom));
    end else begin
      repeat ($urandom_range(4, 1))
        send_request(2'($urandom), NB'($urandom), NB'($urandom), WB'($urandom));
    end
  endtask

  task automatic test_random_graphs();
    int pct [3] = '{0, 73, 32};
    int target;
    // results cannot be held off, so only the sender side gets gaps
    foreach (pct[ph]) begin
      idle_pct = pct[ph];
      target = items_sent + 4;
      while (items_sent < target) random_graph();
    end
    idle_pct = 0;
  endtask

  always @(negedge clk) begin : check_results
    node_distance_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_distances.size() == 0) begin
        flag_error($sformatf("result for node %0d with no run pending", node_index));
      end else begin
        want = pending_distances.pop_front();
        if (node_index !== want.node)
          flag_error($sformatf("node_index %0d, expected %0d", node_index, want.node));
        if (distance !== want.dist_val)
          flag_error($sformatf("node %0d distance %0d, expected %0d", want.node, distance,
                               want.dist_val));
        if (reachable !== want.reach)
          flag_error($sformatf("node %0d reachable %b, expected %b", want.node, reachable,
                               want.reach));
        if (last !== want.is_last)
          flag_error($sformatf("node %0d last %b, expected %b", want.node, last, want.is_last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (start && !busy) || result_valid || psel) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_small_graph();
    test_node_count_limits();
    test_edge_store_full();
    test_random_graphs();
    drain_results();
    repeat (60) @(posedge clk);
    if (pending_distances.size() != 0)
      flag_error($sformatf("%0d node results never arrived", pending_distances.size()));
    $display("summary: %0d requests, %0d runs, %0d node results compared",
             items_sent, runs_sent, results_seen);
    $display("covered: node counts 0..127, stray sources, full edge store, sender gaps");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### bellman_ford_shortest_path_core.f
design/bfsp_pkg.sv
design/bfsp_ram.sv
design/bfsp_edge_store.sv
design/bfsp_relax.sv
design/bfsp_ctrl.sv
design/bellman_ford_shortest_path_core.sv
tb/bellman_ford_shortest_path_core_tb.sv
